// ===== design/udiv64_pkg.sv =====
// ----------------------------------------------------------------------------
// udiv64_pkg
// Shared types and constants for the unsigned divider: field width,
// controller states and the command/status bundles between the modules.
// ----------------------------------------------------------------------------
package udiv64_pkg;

	// width of every operand and result port
	localparam int FIELD_W = 64;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture operands from the input beat
		logic step;    // one radix-4 digit iteration
		logic finish;  // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;    // zero divisor or dividend below divisor
	} status_t;

endpackage

// ===== design/unsigned_divide_64_core.sv =====
// ----------------------------------------------------------------------------
// unsigned_divide_64_core
// Unsigned integer divider giving floor quotient and remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries dividend and divisor (in_valid / in_stall); a beat
//   is taken when in_valid is high and in_stall is low. Output channel
//   carries quotient, remainder and divide_by_zero (out_valid / out_stall).
//   Only the low DATA_WIDTH bits of each operand are used; result bits above
//   DATA_WIDTH are zero.
//   A zero divisor sets divide_by_zero, returns an all-ones quotient and the
//   dividend as remainder.
// Timing:
//   One beat is worked at a time. The radix-4 loop retires two quotient bits
//   per cycle: a general divide runs the digit loop in ST_BUSY, then
//   ST_FINISH moves the result into the output register and raises
//   out_valid. A zero divisor or a dividend below the divisor skips the
//   loop and goes from accept straight to ST_FINISH.
//   The output register holds a finished result while the receiver stalls;
//   the next beat is accepted and worked meanwhile, and waits at its end
//   until the output register is free.
// Reset:
//   arst_n clears the controller and the output valid; no storage to clear.
// ----------------------------------------------------------------------------
module unsigned_divide_64_core
	import udiv64_pkg::*;
#(
	parameter int DATA_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FIELD_W-1:0] dividend,
	input  logic [FIELD_W-1:0] divisor,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] quotient,
	output logic [FIELD_W-1:0] remainder,
	output logic               divide_by_zero
);

	localparam int ITERS = (DATA_WIDTH + 1) / 2;

	cmd_t    cmd;
	status_t status;

	// sequencer
	udiv64_ctrl #(
		.ITERS(ITERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// divide datapath
	udiv64_dpath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.dividend      (dividend),
		.divisor       (divisor),
		.quotient      (quotient),
		.remainder     (remainder),
		.divide_by_zero(divide_by_zero)
	);

endmodule

// ===== design/udiv64_ctrl.sv =====
// ----------------------------------------------------------------------------
// udiv64_ctrl
// Sequencer for the divider: accepts a beat when idle, counts the digit
// iterations and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module udiv64_ctrl
	import udiv64_pkg::*;
#(
	parameter int ITERS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ITERS - 1);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last;

	assign last     = (cnt_q == LAST_CNT);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.skip ? ST_FINISH : ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_BUSY: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state, iteration count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("result not presented after finish");

	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !status.skip |=> state_q == ST_BUSY && cnt_q == '0)
		else $error("iteration did not start after load");

	a_load_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && status.skip |=> state_q == ST_FINISH)
		else $error("early exit not taken");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUSY && last |=> state_q == ST_FINISH)
		else $error("iteration count overran");

endmodule

// ===== design/udiv64_dpath.sv =====
// ----------------------------------------------------------------------------
// udiv64_dpath
// Radix-4 restoring divide datapath: partial remainder, quotient shift
// register, divisor multiples and the output register.
// ----------------------------------------------------------------------------
module udiv64_dpath
	import udiv64_pkg::*;
#(
	parameter int DATA_WIDTH = 64
) (
	input  logic               clk,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [FIELD_W-1:0] dividend,
	input  logic [FIELD_W-1:0] divisor,
	output logic [FIELD_W-1:0] quotient,
	output logic [FIELD_W-1:0] remainder,
	output logic               divide_by_zero
);

	localparam int DW = DATA_WIDTH;
	// dividend padded to an even number of bits, two bits per iteration
	localparam int NW = ((DW + 1) / 2) * 2;

	logic [DW-1:0] n;
	logic [DW-1:0] d;
	logic          d_zero;
	logic          n_below;

	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   d_q;
	logic [DW+1:0]   d3_q;
	logic            zero_q;

	logic [DW+1:0]   partial;
	logic [DW+2:0]   s1;
	logic [DW+2:0]   s2;
	logic [DW+2:0]   s3;
	logic [1:0]      digit;
	logic [DW-1:0]   rem_next;

	logic [FIELD_W-1:0] quotient_q;
	logic [FIELD_W-1:0] remainder_q;
	logic               zero_out_q;

	// operand masking and early-exit detection
	assign n       = dividend[DW-1:0];
	assign d       = divisor[DW-1:0];
	assign d_zero  = (d == '0);
	assign n_below = (n < d);
	assign status.skip = d_zero || n_below;

	// trial subtraction of 3d, 2d and d from the shifted remainder
	assign partial = {rem_q, quo_q[NW-1 -: 2]};
	assign s3 = {1'b0, partial} - {1'b0, d3_q};
	assign s2 = {1'b0, partial} - {2'b0, d_q, 1'b0};
	assign s1 = {1'b0, partial} - {3'b0, d_q};

	// largest multiple that does not borrow
	always_comb begin
		priority if (!s3[DW+2]) begin
			digit    = 2'd3;
			rem_next = s3[DW-1:0];
		end else if (!s2[DW+2]) begin
			digit    = 2'd2;
			rem_next = s2[DW-1:0];
		end else if (!s1[DW+2]) begin
			digit    = 2'd1;
			rem_next = s1[DW-1:0];
		end else begin
			digit    = 2'd0;
			rem_next = partial[DW-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q    <= d;
			d3_q   <= {2'b0, d} + {1'b0, d, 1'b0};
			zero_q <= d_zero;
			if (d_zero) begin
				quo_q <= '1;
				rem_q <= n;
			end else if (n_below) begin
				quo_q <= '0;
				rem_q <= n;
			end else begin
				quo_q <= NW'(n);
				rem_q <= '0;
			end
		end else if (cmd.step) begin
			quo_q <= {quo_q[NW-3:0], digit};
			rem_q <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			quotient_q  <= FIELD_W'(quo_q[DW-1:0]);
			remainder_q <= FIELD_W'(rem_q);
			zero_out_q  <= zero_q;
		end
	end

	assign quotient       = quotient_q;
	assign remainder      = remainder_q;
	assign divide_by_zero = zero_out_q;

endmodule

// ===== tb/sv/unsigned_divide_64_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_divide_64_core_test
// Self-checking bench for the 64-bit unsigned divider. Operand beats go in
// through the valid/stall input channel. An in-bench floor-division model
// predicts quotient, remainder and the zero-divisor flag for every accepted
// beat. Each result beat is checked in order against the oldest prediction.
// The stimulus starts with directed corner operands and then runs shaped
// random pairs through several sender idle and receiver stall mixes. One
// long receiver hold-off makes the core back up and stall its input.
// ----------------------------------------------------------------------------
module unsigned_divide_64_core_test
	import udiv64_pkg::*;
();

	localparam int DATA_WIDTH     = 64;
	localparam int PHASE_ITEMS    = 330;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 40;
	localparam int MAX_REPORTS    = 10;

	// one predicted result, with the operands kept for reporting
	typedef struct packed {
		logic [FIELD_W-1:0] num;
		logic [FIELD_W-1:0] den;
		logic [FIELD_W-1:0] quo;
		logic [FIELD_W-1:0] rem;
		logic               by_zero;
	} quotient_entry_t;

	// scoreboard: floor-division model plus in-order result check
	class division_checker;
		quotient_entry_t awaiting[$];
		int              failures;

		function new();
			failures = 0;
		endfunction

		// floor division within DATA_WIDTH bits, zero divisor flagged
		function quotient_entry_t divide_floor(logic [FIELD_W-1:0] num_in,
				logic [FIELD_W-1:0] den_in);
			logic [FIELD_W-1:0] width_mask;
			quotient_entry_t    res;
			width_mask  = {FIELD_W{1'b1}} >> (FIELD_W - DATA_WIDTH);
			res.num     = num_in;
			res.den     = den_in;
			res.by_zero = 1'b0;
			if ((den_in & width_mask) == '0) begin
				res.quo     = width_mask;
				res.rem     = num_in & width_mask;
				res.by_zero = 1'b1;
			end else begin
				res.quo = (num_in & width_mask) / (den_in & width_mask);
				res.rem = (num_in & width_mask) % (den_in & width_mask);
			end
			return res;
		endfunction

		function void note_operands(logic [FIELD_W-1:0] num_in,
				logic [FIELD_W-1:0] den_in);
			awaiting.push_back(divide_floor(num_in, den_in));
		endfunction

		function void check_result(logic [FIELD_W-1:0] quo_in,
				logic [FIELD_W-1:0] rem_in, logic flag_in);
			quotient_entry_t exp_res;
			if (awaiting.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result beat: quotient %h remainder %h flag %b",
						quo_in, rem_in, flag_in);
				return;
			end
			exp_res = awaiting.pop_front();
			if (quo_in !== exp_res.quo || rem_in !== exp_res.rem ||
					flag_in !== exp_res.by_zero) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("mismatch for %h / %h:", exp_res.num, exp_res.den);
					$display("  quotient  exp %h got %h", exp_res.quo, quo_in);
					$display("  remainder exp %h got %h", exp_res.rem, rem_in);
					$display("  flag      exp %b got %b", exp_res.by_zero, flag_in);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [FIELD_W-1:0] dividend;
	logic [FIELD_W-1:0] divisor;
	logic               out_valid;
	logic               out_stall;
	logic [FIELD_W-1:0] quotient;
	logic [FIELD_W-1:0] remainder;
	logic               divide_by_zero;

	division_checker sb;
	int              send_idle_pct;
	int              stall_pct;
	bit              holdoff_request;
	int              holdoff_left;

	unsigned_divide_64_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.dividend      (dividend),
		.divisor       (divisor),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.quotient      (quotient),
		.remainder     (remainder),
		.divide_by_zero(divide_by_zero)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (holdoff_request) begin
			holdoff_request = 1'b0;
			holdoff_left    = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(quotient, remainder, divide_by_zero);
	end

	// offer one operand beat, idling first at the current rate
	task automatic send_operands(logic [FIELD_W-1:0] num_in, logic [FIELD_W-1:0] den_in);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			dividend <= {$urandom, $urandom};
			divisor  <= {$urandom, $urandom};
			@(negedge clk);
		end
		in_valid <= 1'b1;
		dividend <= num_in;
		divisor  <= den_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_operands(num_in, den_in);
	endtask

	// random operand of random bit length, often full width
	function automatic logic [FIELD_W-1:0] random_operand();
		logic [FIELD_W-1:0] val;
		int                 len;
		val = {$urandom, $urandom};
		if ($urandom_range(99) < 30)
			return val;
		len = $urandom_range(FIELD_W, 0);
		return (len == 0) ? '0 : val >> (FIELD_W - len);
	endfunction

	// shaped random pair: zero divisor, equal, below, near multiple, 32-bit divisor
	task automatic send_random();
		logic [FIELD_W-1:0] num_val;
		logic [FIELD_W-1:0] den_val;
		int                 sel;
		num_val = random_operand();
		den_val = random_operand();
		sel     = $urandom_range(99);
		if (sel < 4)
			den_val = '0;
		else if (sel < 8)
			num_val = den_val;
		else if (sel < 16 && den_val != '0)
			num_val = num_val % den_val;
		else if (sel < 26)
			num_val = den_val * $urandom_range(15, 1) + $urandom_range(3);
		else if (sel < 38)
			den_val = {32'h0, $urandom};
		send_operands(num_val, den_val);
	endtask

	// main sequence
	initial begin
		sb              = new();
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		dividend        = '0;
		divisor         = '0;
		out_stall       = 1'b0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		holdoff_request = 1'b0;
		holdoff_left    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		send_operands('0, '0);
		send_operands({FIELD_W{1'b1}}, '0);
		send_operands('0, {FIELD_W{1'b1}});
		send_operands({FIELD_W{1'b1}}, {FIELD_W{1'b1}});
		send_operands({FIELD_W{1'b1}}, 64'd1);
		send_operands(64'd1, {FIELD_W{1'b1}});
		send_operands({FIELD_W{1'b1}}, 64'd2);
		send_operands(64'h8000_0000_0000_0000, 64'd3);
		send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		send_operands(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
		send_operands({FIELD_W{1'b1}}, 64'hffff_ffff);
		send_operands({FIELD_W{1'b1}}, 64'h1_0000_0000);
		send_operands({FIELD_W{1'b1}}, 64'hffff);
		send_operands(64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def0);
		send_operands(64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def1);
		send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_operands(64'hffff_ffff_0000_0000, 64'hffff_ffff_ffff_fffe);
		send_operands(64'd100, 64'd7);
		send_operands(64'd0, 64'd5);
		send_operands(64'h0000_0001_0000_0000, 64'h0000_0000_ffff_ffff);

		// receiver holds off while the sender keeps offering
		@(posedge clk);
		holdoff_request = 1'b1;
		repeat (30)
			send_random();

		// random phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 29 : 0;
			stall_pct     = (phase == 2) ? 79 : (phase == 3) ? 29 : 0;
			repeat (PHASE_ITEMS)
				send_random();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain
		while (sb.awaiting.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.awaiting.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/udiv64_pkg.sv
design/udiv64_ctrl.sv
design/udiv64_dpath.sv
design/unsigned_divide_64_core.sv
tb/sv/unsigned_divide_64_core_test.sv
